@@ hdl/bpa_pkg.sv @@
// bpa_pkg: shared constants, status codes and a helper function of the
// bitmap page allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

	localparam int ADDR_W     = 48;
	localparam int INDEX_W    = 6;
	localparam int STATUS_W   = 3;
	localparam int USED_W     = 7;
	localparam int WORD_W     = 32;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOMEM         = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISALIGNED    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE         = 3'd4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	// position of the lowest clear bit, zero when the word is all ones
	function automatic logic [BIT_W-1:0] lowest_zero(input word_t w);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				pos = BIT_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

@@ hdl/bitmap_page_allocator.sv @@
// Allocate: first-fit scan of 1 to PAGE_COUNT/32 (rounded up) bitmap words, then the address sum;
// allocate on a full pool skips the scan; one word per cycle goes through the lowest-clear finder.
// Free: subtract, range check, bitmap read, bitmap write; ends at the check if misaligned/out of range.
// One command at a time; in_stall is high until the result sits in the output register.
// Reset clears state and count at once; bitmap rows carry valid flags, no clearing pass.
// bitmap_page_allocator: top level, sequencer and result register. Depends on bpa_pkg, bpa_bitmap.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int PAGE_COUNT = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr_en,
	input  wire  [ADDR_W-1:0]   cfg_wr_data,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire                 cmd,
	input  wire  [ADDR_W-1:0]   free_address,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [ADDR_W-1:0]   page_address,
	output logic [INDEX_W-1:0]  page_index,
	output logic [STATUS_W-1:0] status,
	output logic [USED_W-1:0]   used_count
);

	localparam int NUM_WORDS = (PAGE_COUNT + WORD_W - 1) / WORD_W;
	localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int SLOT_W    = WIDX_W + BIT_W;
	localparam int CNT_W     = $clog2(PAGE_COUNT + 1);
	localparam int HI_W      = ADDR_W - PAGE_SHIFT;
	localparam int LAST_BITS = PAGE_COUNT - (NUM_WORDS - 1) * WORD_W;
	localparam word_t LAST_PAD = {WORD_W{1'b1}} << LAST_BITS;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_FREE_CHK  = 3'd1;
	localparam logic [2:0] S_FREE_RD   = 3'd2;
	localparam logic [2:0] S_SCAN      = 3'd3;
	localparam logic [2:0] S_ALLOC_ADR = 3'd4;
	localparam logic [2:0] S_FINISH    = 3'd5;

	logic [2:0]          state_q;
	logic [ADDR_W-1:0]   base_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [WIDX_W-1:0]   word_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [ADDR_W-1:0]   diff_q;
	logic                borrow_q;
	logic                misal_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic [INDEX_W-1:0]  res_idx_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   page_address_q;
	logic [INDEX_W-1:0]  page_index_q;
	logic [STATUS_W-1:0] status_q;
	logic [USED_W-1:0]   used_count_q;

	logic                in_xfer;
	logic                out_free;
	logic [ADDR_W:0]     diff_full;
	logic                full;
	logic                wr_en;
	logic [WIDX_W-1:0]   wr_row;
	word_t               wr_data;
	logic [WIDX_W-1:0]   rd_row;
	word_t               rd_word;
	word_t               scan_word;
	logic [BIT_W-1:0]    zero_pos;
	logic [SLOT_W-1:0]   chk_slot;
	logic [CNT_W+USED_W-1:0] cnt_ext;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign diff_full = {1'b0, free_address} - {1'b0, base_q};
	assign full      = (cnt_q == CNT_W'(PAGE_COUNT));
	assign chk_slot  = diff_q[PAGE_SHIFT +: SLOT_W];

	// pad bits past the pool in the last word read as taken
	assign scan_word = rd_word | ((word_q == WIDX_W'(NUM_WORDS - 1)) ? LAST_PAD : '0);
	assign zero_pos  = lowest_zero(scan_word);

	always_comb begin
		rd_row  = '0;
		wr_en   = 1'b0;
		wr_row  = word_q;
		wr_data = rd_word;
		case (state_q)
			S_FREE_CHK: begin
				rd_row = chk_slot[SLOT_W-1 -: WIDX_W];
			end
			S_FREE_RD: begin
				wr_row  = slot_q[SLOT_W-1 -: WIDX_W];
				wr_en   = rd_word[slot_q[BIT_W-1:0]];
				wr_data = rd_word & ~(WORD_W'(1) << slot_q[BIT_W-1:0]);
			end
			S_SCAN: begin
				rd_row  = word_q + 1'b1;
				wr_en   = (~scan_word != '0);
				wr_data = rd_word | (WORD_W'(1) << zero_pos);
			end
			default: begin
				rd_row = '0;
			end
		endcase
	end

	bpa_bitmap #(
		.ROWS   (NUM_WORDS),
		.ROW_AW (WIDX_W)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_row  (wr_row),
		.wr_data (wr_data),
		.rd_row  (rd_row),
		.rd_data (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
		end else if (cfg_wr_en) begin
			base_q  <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (cmd == CMD_FREE) begin
							state_q <= S_FREE_CHK;
						end else if (full) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_FREE_CHK: begin
					if (misal_q || borrow_q ||
					    diff_q[ADDR_W-1:PAGE_SHIFT] >= HI_W'(PAGE_COUNT)) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_FREE_RD;
					end
				end
				S_FREE_RD: begin
					if (wr_en) begin
						cnt_q <= cnt_q - 1'b1;
					end
					state_q <= S_FINISH;
				end
				S_SCAN: begin
					if (wr_en) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_ALLOC_ADR;
					end
				end
				S_ALLOC_ADR: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cnt_ext = {{USED_W{1'b0}}, cnt_q};

	// working and result payload, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				diff_q       <= diff_full[ADDR_W-1:0];
				borrow_q     <= diff_full[ADDR_W];
				misal_q      <= |free_address[PAGE_SHIFT-1:0];
				word_q       <= '0;
				res_addr_q   <= '0;
				res_idx_q    <= '0;
				res_status_q <= ST_NOMEM;
			end
			S_FREE_CHK: begin
				slot_q <= chk_slot;
				if (misal_q) begin
					res_status_q <= ST_MISALIGNED;
				end else begin
					res_status_q <= ST_RANGE;
				end
			end
			S_FREE_RD: begin
				res_idx_q    <= slot_q[INDEX_W-1:0];
				res_status_q <= wr_en ? ST_OK : ST_NOT_ALLOCATED;
			end
			S_SCAN: begin
				slot_q <= {word_q, zero_pos};
				word_q <= word_q + 1'b1;
			end
			S_ALLOC_ADR: begin
				res_addr_q   <= base_q + ADDR_W'({slot_q, {PAGE_SHIFT{1'b0}}});
				res_idx_q    <= slot_q[INDEX_W-1:0];
				res_status_q <= ST_OK;
			end
			S_FINISH: begin
				if (out_free) begin
					page_address_q <= res_addr_q;
					page_index_q   <= res_idx_q;
					status_q       <= res_status_q;
					used_count_q   <= cnt_ext[USED_W-1:0];
				end
			end
			default: begin
				word_q <= '0;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign page_address = page_address_q;
	assign page_index   = page_index_q;
	assign status       = status_q;
	assign used_count   = used_count_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PAGE_COUNT))
		else $error("used page count above pool size");

	a_scan_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> word_q <= WIDX_W'(NUM_WORDS - 1))
		else $error("first-fit scan ran past the last bitmap word");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) ||
		(cnt_q == $past(cnt_q) - 1'b1))
		else $error("used page count moved by more than one");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished command did not reach the output register");

	a_full_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && cmd == CMD_ALLOC && full) |=> state_q == S_FINISH)
		else $error("scan started on a full pool");

endmodule

`default_nettype wire

@@ hdl/bpa_bitmap.sv @@
// bpa_bitmap: word-wide allocation bitmap memory with a registered read port
// and one valid flag per row so that reset reads every page as free.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpa_bitmap
	import bpa_pkg::*;
#(
	parameter int ROWS   = 2,
	parameter int ROW_AW = 1
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                wr_en,
	input  wire   [ROW_AW-1:0] wr_row,
	input  wire   word_t       wr_data,
	input  wire   [ROW_AW-1:0] rd_row,
	output word_t              rd_data
);

	word_t            mem [ROWS];
	logic  [ROWS-1:0] row_valid_q;
	word_t            rd_mem_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		rd_mem_q <= mem[rd_row];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			rd_vld_q <= row_valid_q[rd_row];
		end
	end

	// a row never written since reset holds only free pages
	assign rd_data = rd_vld_q ? rd_mem_q : '0;

endmodule

`default_nettype wire
